/* src/kmp_stream_matcher_assert.svh */
// Assertion macros for the matcher RTL, used by the top level kmp_stream_matcher.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef KMP_STREAM_MATCHER_ASSERT_SVH
`define KMP_STREAM_MATCHER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset
`define KMS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset
`define KMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define KMS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define KMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* src/kms_pkg.sv */
// Shared types and constants for the streaming KMP matcher.
// No dependencies; used by kms_cfg, kms_cell and kmp_stream_matcher.
`timescale 1ns / 1ps
`default_nettype none

package kms_pkg;

    // Default parameter values
    localparam int PATTERN_MAX_DEF = 8;
    localparam int POS_BITS_DEF    = 32;

    // Fixed field widths
    localparam int PAT_W   = 64;
    localparam int LEN_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int START_W = 32;
    localparam int COUNT_W = 32;
    localparam int OUT_W   = 72;  // 1 + 32 + 32 bits, padded to whole bytes
    localparam int ADDR_W  = 4;

    // Patterns never exceed the width of the pattern register
    localparam int PAT_BYTES = PAT_W / BYTE_W;

    // Register index codes (paddr[3])
    localparam logic REG_PATTERN = 1'b0;
    localparam logic REG_LENGTH  = 1'b1;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [PAT_W-1:0] pattern;
        logic [LEN_W-1:0] act_len;   // length clamped to the cell count
        logic             reload;    // pulse on any register write
    } cfg_t;

endpackage

`default_nettype wire

/* src/kms_cfg.sv */
// APB register file: pattern bytes and pattern length.
// Depends on kms_pkg; feeds cfg_t to the matcher datapath.
`timescale 1ns / 1ps
`default_nettype none

module kms_cfg #(
    parameter int PATTERN_MAX = kms_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [kms_pkg::ADDR_W-1:0] paddr,
    input  wire logic [kms_pkg::PAT_W-1:0]  pwdata,
    output logic      [kms_pkg::PAT_W-1:0]  prdata,
    output logic                            pready,
    output kms_pkg::cfg_t                   cfg
);
    import kms_pkg::*;

    localparam int CAP = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;

    logic [PAT_W-1:0] pattern_reg;
    logic [LEN_W-1:0] length_reg;
    logic             wr_en;
    logic             reg_sel;

    // Registers sit on 8-byte boundaries; bit 3 picks the register
    assign reg_sel = paddr[3];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            length_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                case (reg_sel)
                    REG_PATTERN: pattern_reg <= pwdata;
                    REG_LENGTH:  length_reg  <= pwdata[LEN_W-1:0];
                    default:     pattern_reg <= pattern_reg;
                endcase
            end
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_sel)
            REG_PATTERN: prdata = pattern_reg;
            REG_LENGTH:  prdata = {{(PAT_W-LEN_W){1'b0}}, length_reg};
            default:     prdata = '0;
        endcase
    end

    // Clamp length to the number of cells; reload clears the chain on the write edge
    always_comb
    begin
        cfg.pattern = pattern_reg;
        cfg.reload  = wr_en;
        if (length_reg > LEN_W'(CAP))
            cfg.act_len = LEN_W'(CAP);
        else
            cfg.act_len = length_reg;
    end

endmodule

`default_nettype wire

/* src/kms_cell.sv */
// One compare cell of the matcher chain: holds one pattern byte's prefix-hit flag.
// Depends on kms_pkg; instantiated once per pattern position by the top level.
`timescale 1ns / 1ps
`default_nettype none

module kms_cell (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       advance,    // text beat accepted
    input  wire logic                       flush,      // clear the prefix state
    input  wire logic [kms_pkg::BYTE_W-1:0] text_byte,
    input  wire logic [kms_pkg::BYTE_W-1:0] pat_byte,
    input  wire logic                       prev_hit,   // neighbour's flag (1 for cell 0)
    input  wire logic                       is_tail,    // this cell is the pattern's last
    output logic                            hit,        // registered flag to next cell
    output logic                            tail_hit    // full match ends at this beat
);
    import kms_pkg::*;

    logic hit_reg;
    logic hit_next;

    // Prefix of length k+1 ends here if prefix k ended one byte back and bytes agree
    assign hit_next = prev_hit && (text_byte == pat_byte);
    assign tail_hit = hit_next && is_tail;
    assign hit      = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else if (flush)
            hit_reg <= 1'b0;
        else if (advance)
            hit_reg <= hit_next;
    end

endmodule

`default_nettype wire

/* src/kmp_stream_matcher.sv */
// Top level of the streaming KMP matcher: stream ports, cell chain, counters.
// Depends on kms_pkg, kms_cfg, kms_cell and kmp_stream_matcher_assert.svh.
// The result beat is registered and becomes valid the cycle after its text beat is accepted.
// Throughput: one text byte per cycle while the result output is not stalled; every cell
// compares its byte and hands its prefix flag to the next cell, so the chain takes one byte a beat.
// Reset (rst_n low, asynchronous) clears the config registers, output valid flag, cell flags and counters.
`timescale 1ns / 1ps
`default_nettype none

`include "kmp_stream_matcher_assert.svh"

module kmp_stream_matcher #(
    parameter int PATTERN_MAX   = kms_pkg::PATTERN_MAX_DEF,
    parameter int POSITION_BITS = kms_pkg::POS_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // text in
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [kms_pkg::BYTE_W-1:0]  s_tdata,   // [7:0] text_byte
    input  wire logic                        s_tlast,   // text_end
    // results out
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [kms_pkg::OUT_W-1:0]   m_tdata,   // [0] match_found,
                                                        // [32:1] match_start,
                                                        // [64:33] match_total
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [kms_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [kms_pkg::PAT_W-1:0]   pwdata,
    output logic      [kms_pkg::PAT_W-1:0]   prdata,
    output logic                             pready
);
    import kms_pkg::*;

    cfg_t cfg;

    logic                     accept;
    logic                     flush;
    logic [PATTERN_MAX-1:0]   cell_hit;
    logic [PATTERN_MAX-1:0]   tail_hit;
    logic                     found;

    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [POSITION_BITS-1:0] start_full;
    logic [COUNT_W-1:0]       cnt_reg;
    logic [COUNT_W-1:0]       cnt_next;
    logic [COUNT_W-1:0]       total;

    logic                     out_valid_reg;
    logic                     found_reg;
    logic [START_W-1:0]       start_reg;
    logic [COUNT_W-1:0]       total_reg;

    // Register file
    kms_cfg #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Handshake: output register frees up when its beat is taken
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign flush    = cfg.reload || (accept && s_tlast);

    // Cell chain
    generate
        for (genvar k = 0; k < PATTERN_MAX; k++)
        begin : g_cell
            logic [BYTE_W-1:0] pat_b;
            logic              prev;
            logic              tail;

            if (k < PAT_BYTES)
            begin : g_byte
                assign pat_b = cfg.pattern[BYTE_W*k +: BYTE_W];
            end
            else
            begin : g_zero
                assign pat_b = '0;
            end

            if (k == 0)
            begin : g_head
                assign prev = 1'b1;
            end
            else
            begin : g_link
                assign prev = cell_hit[k-1];
            end

            assign tail = (int'(cfg.act_len) == k + 1);

            kms_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (accept),
                .flush     (flush),
                .text_byte (s_tdata),
                .pat_byte  (pat_b),
                .prev_hit  (prev),
                .is_tail   (tail),
                .hit       (cell_hit[k]),
                .tail_hit  (tail_hit[k])
            );
        end
    endgenerate

    // Match detect, start position and saturating count
    assign found      = |tail_hit;
    assign start_full = pos_reg - POSITION_BITS'(cfg.act_len) + POSITION_BITS'(1);

    always_comb
    begin
        total    = cnt_reg;
        if (found && (cnt_reg != '1))
            total = cnt_reg + COUNT_W'(1);
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                cnt_next = '0;
                pos_next = '0;
            end
            else
            begin
                cnt_next = total;
                pos_next = pos_reg + POSITION_BITS'(1);
            end
        end
    end

    // End-of-text clears the cell flags too; kept apart from config reload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            cnt_reg <= cnt_next;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            found_reg <= found;
            start_reg <= found ? START_W'(start_full) : '0;
            total_reg <= total;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - 1 - START_W - COUNT_W){1'b0}}, total_reg, start_reg, found_reg};

    // Assertions
    `KMS_ASSERT_NOW(a_found_counts, clk, rst_n, m_tvalid && found_reg, total_reg != '0)
    `KMS_ASSERT_NOW(a_miss_start_zero, clk, rst_n, m_tvalid && !found_reg, start_reg == '0)
    `KMS_ASSERT_NEXT(a_end_clears, clk, rst_n, accept && s_tlast, pos_reg == '0 && cnt_reg == '0)
    `KMS_ASSERT_NOW(a_empty_no_match, clk, rst_n, cfg.act_len == '0, tail_hit == '0)
    `KMS_ASSERT_NOW(a_one_tail, clk, rst_n, 1'b1, $onehot0(tail_hit))

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the streaming KMP matcher (kmp_stream_matcher).
// Depends on kms_pkg and the matcher RTL. Text beats are driven from a queue,
// predicted in step and each result beat is checked against the prediction.
`timescale 1ns / 1ps

module tb_top;
    import kms_pkg::*;

    localparam int unsigned RUN_LIMIT  = 400000;
    localparam int unsigned LONG_HOLD  = 300;
    localparam int unsigned LIVE_BYTES = 8;

    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic              fin;
    } text_beat_t;

    typedef struct {
        logic               found;
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] total;
    } match_res_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata;   // [7:0] text_byte
    logic              s_tlast;   // text_end
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;   // [0] match_found, [32:1] match_start, [64:33] match_total
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [PAT_W-1:0]  pwdata;
    logic [PAT_W-1:0]  prdata;
    logic              pready;

    // Text waiting to go out and results still owed by the block
    text_beat_t  text_q[$];
    match_res_t  match_q[$];
    logic        in_taken;
    int unsigned send_idle;
    int unsigned recv_idle;
    int unsigned hold_asked;
    int unsigned hold_done;
    int unsigned hold_left;
    int unsigned cycles;
    int unsigned errors;

    // Matcher state as the block should hold it
    logic [PAT_W-1:0]   pat_reg;
    logic [LEN_W-1:0]   len_reg;
    int unsigned        cur_len;
    logic [START_W-1:0] text_pos;
    logic [COUNT_W-1:0] match_cnt;
    int unsigned        fail_tab[LIVE_BYTES];

    // Symbols used to build patterns and texts that hit them
    logic [BYTE_W-1:0]  alpha[3];
    int unsigned        alpha_n;

    kmp_stream_matcher DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    // Pattern length in use: clamped to the cell count
    function automatic int unsigned eff_len();
        return (len_reg > LIVE_BYTES) ? LIVE_BYTES : int'(len_reg);
    endfunction

    function automatic logic [BYTE_W-1:0] pat_char(input int unsigned k);
        return (k >= LIVE_BYTES) ? '0 : pat_reg[8*k +: 8];
    endfunction

    // Prefix function of the live pattern; also drops any partial match
    function automatic void rebuild_prefix();
        int unsigned m;
        int unsigned i;
        int unsigned j;
        m = eff_len();
        for (i = 0; i < LIVE_BYTES; i++)
            fail_tab[i] = 0;
        for (i = 1; i < m; i++)
        begin
            j = fail_tab[i-1];
            while (j > 0 && pat_char(i) != pat_char(j))
                j = fail_tab[j-1];
            if (pat_char(i) == pat_char(j))
                j++;
            fail_tab[i] = j;
        end
        cur_len = 0;
    endfunction

    // One text byte through the matcher: result of that byte, state advanced
    function automatic match_res_t kmp_scan(input logic [BYTE_W-1:0] ch, input logic fin);
        match_res_t  r;
        int unsigned m;
        int unsigned j;
        m = eff_len();
        j = cur_len;
        r.found = 1'b0;
        r.start = '0;
        if (m > 0)
        begin
            if (j >= m)
                j = 0;
            while (j > 0 && ch != pat_char(j))
                j = fail_tab[j-1];
            if (ch == pat_char(j))
                j++;
            if (j == m)
            begin
                r.found = 1'b1;
                r.start = text_pos - START_W'(m) + START_W'(1);
                j = fail_tab[j-1];
                if (match_cnt != '1)
                    match_cnt++;
            end
        end
        else
            j = 0;
        cur_len = j;
        r.total = match_cnt;
        text_pos++;
        if (fin)
        begin
            cur_len = 0;
            text_pos = '0;
            match_cnt = '0;
        end
        return r;
    endfunction

    // Register write: setup then access; predictor follows once it lands
    task automatic reg_write(input logic idx, input logic [PAT_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready)
            @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_PATTERN)
            pat_reg = val;
        else
            len_reg = val[LEN_W-1:0];
        rebuild_prefix();
    endtask

    task automatic push_beat(input logic [BYTE_W-1:0] ch, input logic fin);
        text_beat_t b;
        b.ch  = ch;
        b.fin = fin;
        text_q = {text_q, b};
    endtask

    // Wait until nothing is queued, offered or owed, then a short margin
    task automatic drain();
        int unsigned n;
        n = 0;
        while ((text_q.size() != 0 || s_tvalid || match_q.size() != 0) && n < RUN_LIMIT)
        begin
            @(negedge clk);
            n++;
        end
        repeat (3) @(negedge clk);
    endtask

    // Fresh pattern over a small alphabet, registers written in random order
    task automatic new_pattern(input int unsigned len);
        logic [PAT_W-1:0] p;
        logic [PAT_W-1:0] lv;
        int unsigned      i;
        alpha_n = $urandom_range(2, 3);
        for (i = 0; i < 3; i++)
            alpha[i] = BYTE_W'($urandom_range(255));
        p = {$urandom, $urandom};
        for (i = 0; i < LIVE_BYTES; i++)
            if ($urandom_range(7) != 0)
                p[8*i +: 8] = alpha[$urandom_range(alpha_n - 1)];
        lv = {$urandom, $urandom};
        lv[LEN_W-1:0] = len[LEN_W-1:0];
        if ($urandom_range(1))
        begin
            reg_write(REG_PATTERN, p);
            reg_write(REG_LENGTH, lv);
        end
        else
        begin
            reg_write(REG_LENGTH, lv);
            reg_write(REG_PATTERN, p);
        end
    endtask

    // Mostly pattern copies and alphabet symbols, some noise bytes
    task automatic queue_text(input int unsigned n, input bit close_end);
        int unsigned k;
        int unsigned r;
        int unsigned i;
        int unsigned cut;
        int unsigned plen;
        k = 0;
        plen = (eff_len() > 0) ? eff_len() : 4;
        while (k < n)
        begin
            r = $urandom_range(99);
            if (r < 35)
            begin
                cut = ($urandom_range(3) == 0) ? $urandom_range(1, plen) : plen;
                for (i = 0; i < cut && k < n; i++)
                begin
                    push_beat(pat_char(i), $urandom_range(39) == 0);
                    k++;
                end
            end
            else
            begin
                if (r < 85)
                    push_beat(alpha[$urandom_range(alpha_n - 1)], $urandom_range(39) == 0);
                else
                    push_beat(BYTE_W'($urandom_range(255)), $urandom_range(39) == 0);
                k++;
            end
        end
        if (close_end)
            text_q[text_q.size() - 1].fin = 1'b1;
    endtask

    // Sender: next text beat from the queue, with random gaps
    always @(negedge clk)
    begin : text_driver
        text_beat_t b;
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (text_q.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                b = text_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= b.ch;
                s_tlast  <= b.fin;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus a long hold when one is asked for
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (hold_asked != hold_done)
        begin
            hold_done = hold_asked;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Predict on each accepted text beat, check each accepted result beat
    always @(posedge clk)
    begin : result_check
        match_res_t want;
        in_taken = rst_n && s_tvalid && s_tready;
        if (in_taken)
            match_q = {match_q, kmp_scan(s_tdata, s_tlast)};
        if (rst_n && m_tvalid && m_tready)
        begin
            if (match_q.size() == 0)
            begin
                $error("result beat with no expectation pending");
                errors++;
            end
            else
            begin
                want = match_q.pop_front();
                if (m_tdata[0] !== want.found)
                begin
                    $error("match_found: expected %0d, got %0d", want.found, m_tdata[0]);
                    errors++;
                end
                if (m_tdata[32:1] !== want.start)
                begin
                    $error("match_start: expected %0d, got %0d", want.start, m_tdata[32:1]);
                    errors++;
                end
                if (m_tdata[64:33] !== want.total)
                begin
                    $error("match_total: expected %0d, got %0d", want.total, m_tdata[64:33]);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned mode;
        int unsigned k;
        int unsigned len;
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_taken   = 1'b0;
        send_idle  = 0;
        recv_idle  = 0;
        hold_asked = 0;
        hold_done  = 0;
        hold_left  = 0;
        errors     = 0;
        pat_reg    = '0;
        len_reg    = '0;
        text_pos   = '0;
        match_cnt  = '0;
        alpha_n    = 2;
        alpha[0]   = 8'h61;
        alpha[1]   = 8'h62;
        alpha[2]   = 8'h00;
        rebuild_prefix();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty pattern after reset: positions count, nothing matches
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);
        push_beat(8'hA5, 1'b1);
        drain();

        // Overlapping matches of "aa"
        reg_write(REG_PATTERN, 64'hDEAD_BEEF_C0DE_6161);
        reg_write(REG_LENGTH, 64'h2);
        repeat (4) push_beat(8'h61, 1'b0);
        text_q[text_q.size() - 1].fin = 1'b1;
        drain();

        // Overlong length clamps to eight zero bytes
        reg_write(REG_PATTERN, 64'h0);
        reg_write(REG_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
        repeat (9) push_beat(8'h00, 1'b0);
        text_q[text_q.size() - 1].fin = 1'b1;
        drain();

        // Single byte pattern, text left open
        reg_write(REG_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF);
        reg_write(REG_LENGTH, 64'h1);
        push_beat(8'hFF, 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b0);
        drain();

        // Pattern changed mid-text: position and count carry on
        reg_write(REG_PATTERN, 64'h0000_0000_0061_6261);
        reg_write(REG_LENGTH, 64'h3);
        push_beat(8'h61, 1'b0);
        push_beat(8'h62, 1'b0);
        push_beat(8'h61, 1'b0);
        push_beat(8'h62, 1'b0);
        push_beat(8'h61, 1'b1);
        drain();

        // Random texts under three idling regimes
        for (mode = 0; mode < 3; mode++)
        begin
            send_idle = (mode == 0) ? 27 : (mode == 1) ? 85 : 0;
            recv_idle = (mode == 0) ? 85 : (mode == 1) ? 27 : 0;
            for (k = 0; k < 4; k++)
            begin
                drain();
                if (k == 0)
                    len = (mode == 1) ? 15 : LIVE_BYTES;
                else if (k == 1)
                    len = $urandom_range(1, 3);
                else
                    len = $urandom_range(0, 15);
                new_pattern(len);
                queue_text(120, 1'($urandom_range(1)));
                if (mode == 2 && k == 1)
                    hold_asked++;
            end
        end
        drain();

        if (match_q.size() != 0)
        begin
            $error("%0d expected results never arrived", match_q.size());
            errors++;
        end
        repeat (5) @(posedge clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
